// ----- sv/mkg_pkg.sv -----
// Magnetometer Kalman gate: shared constants, command types and verdict codes.
// Used by mkg_ctrl, mkg_datapath and magnetometer_kalman_gate_unit; no dependencies.
`default_nettype none

package mkg_pkg;

   localparam int SAMPLE_WIDTH   = 16;
   localparam int GAIN_FRAC_BITS = 16;
   localparam int EST_WIDTH      = 24;
   localparam int EXTRA_BITS     = EST_WIDTH - SAMPLE_WIDTH;
   localparam int GAIN_WIDTH     = GAIN_FRAC_BITS + 1;
   localparam int DIFF_WIDTH     = EST_WIDTH + 1;
   localparam int COV_WIDTH      = 32;
   localparam int DEN_WIDTH      = COV_WIDTH + 1;
   localparam int REM_WIDTH      = COV_WIDTH + 2;
   localparam int ACC_WIDTH      = 32;
   localparam int HALF_WIDTH     = ACC_WIDTH / 2;
   localparam int MUL_A_WIDTH    = 34;
   localparam int MUL_B_WIDTH    = 17;
   localparam int PROD_WIDTH     = MUL_A_WIDTH + MUL_B_WIDTH;
   localparam int LO_WIDTH       = MUL_A_WIDTH + HALF_WIDTH;
   localparam int RHS_WIDTH      = LO_WIDTH + HALF_WIDTH;
   localparam int DIV_STEPS      = GAIN_WIDTH;
   localparam int COUNT_WIDTH    = $clog2(DIV_STEPS);

   localparam int SPIKE_LIMIT_WIDTH = 15;
   localparam int PROC_NOISE_WIDTH  = 16;
   localparam int MEAS_NOISE_WIDTH  = 18;
   localparam int RATIO_WIDTH       = 17;
   localparam int CSR_ADDR_WIDTH    = 2;
   localparam int CSR_DATA_WIDTH    = 18;

   localparam int VERDICT_WIDTH  = 2;
   localparam int REQ_DATA_WIDTH = 3 * SAMPLE_WIDTH;
   localparam int RSP_DATA_WIDTH = 3 * SAMPLE_WIDTH;

   localparam logic [SPIKE_LIMIT_WIDTH-1:0] SPIKE_LIMIT_RESET = 15'd800;
   localparam logic [PROC_NOISE_WIDTH-1:0]  PROC_NOISE_RESET  = 16'd2621;
   localparam logic [MEAS_NOISE_WIDTH-1:0]  MEAS_NOISE_RESET  = 18'd32768;
   localparam logic [RATIO_WIDTH-1:0]       RATIO_RESET       = 17'd44564;
   localparam logic [COV_WIDTH-1:0]         COV_RESET =
      COV_WIDTH'(1) << GAIN_FRAC_BITS;
   localparam logic [GAIN_WIDTH-1:0]        GAIN_ONE =
      GAIN_WIDTH'(1) << GAIN_FRAC_BITS;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_SPIKE_LIMIT   = 2'd0,
      CSR_PROCESS_NOISE = 2'd1,
      CSR_MEAS_NOISE    = 2'd2,
      CSR_RATIO_LIMIT   = 2'd3
   } csr_index_type;

   typedef enum logic [VERDICT_WIDTH-1:0] {
      VERDICT_ACCEPT = 2'd0,
      VERDICT_SPIKE  = 2'd1,
      VERDICT_RATIO  = 2'd2
   } verdict_type;

   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_SQ_SAMPLE,
      MUL_SQ_LIMIT,
      MUL_GAIN_DIFF,
      MUL_COV,
      MUL_SQ_EST,
      MUL_SQ_RATIO,
      MUL_R2_LO,
      MUL_R2_HI
   } mul_sel_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_ACC,
      ACT_SPIKE,
      ACT_DEN,
      ACT_DIV,
      ACT_DIFF,
      ACT_UPD,
      ACT_COV,
      ACT_ROUND,
      ACT_ACC_Z,
      ACT_R2,
      ACT_LO,
      ACT_COMB,
      ACT_CMP,
      ACT_OUT
   } act_type;

   typedef struct packed {
      mul_sel_type mul;
      act_type     act;
      logic [1:0]  axis;
   } mkg_cmd_type;

endpackage

`default_nettype wire

// ----- sv/magnetometer_kalman_gate_unit.sv -----
// Magnetometer Kalman gate, top level: sequencer plus datapath.
// Depends on mkg_pkg, mkg_ctrl and mkg_datapath.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  req_tdata: sample_x, sample_y, sample_z
//   rsp      out        rsp_tvalid/rsp_tready  rsp_tdata: filtered_x/y/z; rsp_tuser: verdict
//   csr      in         csr_we                 csr_addr (register index), csr_wdata
//
// When the filter updates, a sample passes from accept to result register through the
// one-bit-per-cycle gain divider and otherwise through single steps of the shared
// 34x17 multiplier or adder. The next beat is taken the cycle after the result is
// loaded, even while that result waits on rsp_tready.
// Synchronous reset restores register defaults, zero estimates and unit covariance.
`default_nettype none

module magnetometer_kalman_gate_unit
   import mkg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,   // sample_x, sample_y, sample_z
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,   // filtered_x, filtered_y, filtered_z
   output logic [VERDICT_WIDTH-1:0]  rsp_tuser,   // verdict
   input  logic                      csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   mkg_cmd_type cmd;
   logic        spike;

   mkg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .spike      (spike),
      .cmd        (cmd)
   );

   mkg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .spike     (spike),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire

// ----- sv/mkg_ctrl.sv -----
// Magnetometer Kalman gate: sequencer that steps the datapath through one sample.
// Depends on mkg_pkg for the command struct.
`default_nettype none

module mkg_ctrl
   import mkg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        spike,
   output mkg_cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MAG,
      ST_CHECK,
      ST_DEN,
      ST_DIV,
      ST_DIFF,
      ST_GMUL,
      ST_UPD,
      ST_COVMUL,
      ST_COVUPD,
      ST_ROUND,
      ST_FSQ,
      ST_RSQ,
      ST_PLO,
      ST_PHI,
      ST_COMB,
      ST_CMP,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [1:0]             axis_ff, axis_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      axis_in      = axis_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.mul      = MUL_NONE;
      cmd.act      = ACT_NONE;
      cmd.axis     = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.act  = ACT_LOAD;
               count_in = '0;
               state_in = ST_MAG;
            end
         end
         ST_MAG: begin
            cmd.axis = count_ff[1:0];
            cmd.mul  = (count_ff == COUNT_WIDTH'(3)) ? MUL_SQ_LIMIT : MUL_SQ_SAMPLE;
            cmd.act  = (count_ff == '0) ? ACT_NONE : ACT_ACC;
            if (count_ff == COUNT_WIDTH'(3)) begin
               state_in = ST_CHECK;
            end else begin
               count_in = count_ff + COUNT_WIDTH'(1);
            end
         end
         ST_CHECK: begin
            cmd.act  = ACT_SPIKE;
            state_in = ST_DEN;
         end
         ST_DEN: begin
            cmd.act  = ACT_DEN;
            count_in = '0;
            state_in = spike ? ST_ROUND : ST_DIV;
         end
         ST_DIV: begin
            cmd.act = ACT_DIV;
            if (count_ff == COUNT_WIDTH'(DIV_STEPS - 1)) begin
               axis_in  = '0;
               state_in = ST_DIFF;
            end else begin
               count_in = count_ff + COUNT_WIDTH'(1);
            end
         end
         ST_DIFF: begin
            cmd.act  = ACT_DIFF;
            state_in = ST_GMUL;
         end
         ST_GMUL: begin
            cmd.mul  = MUL_GAIN_DIFF;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            cmd.act = ACT_UPD;
            if (axis_ff == 2'd2) begin
               state_in = ST_COVMUL;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_DIFF;
            end
         end
         ST_COVMUL: begin
            cmd.mul  = MUL_COV;
            state_in = ST_COVUPD;
         end
         ST_COVUPD: begin
            cmd.act  = ACT_COV;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.act  = ACT_ROUND;
            count_in = '0;
            state_in = spike ? ST_FINISH : ST_FSQ;
         end
         ST_FSQ: begin
            cmd.axis = count_ff[1:0];
            cmd.mul  = (count_ff == COUNT_WIDTH'(3)) ? MUL_SQ_RATIO : MUL_SQ_EST;
            if (count_ff == '0) begin
               cmd.act = ACT_NONE;
            end else if (count_ff == COUNT_WIDTH'(3)) begin
               cmd.act = ACT_ACC_Z;
            end else begin
               cmd.act = ACT_ACC;
            end
            if (count_ff == COUNT_WIDTH'(3)) begin
               state_in = ST_RSQ;
            end else begin
               count_in = count_ff + COUNT_WIDTH'(1);
            end
         end
         ST_RSQ: begin
            cmd.act  = ACT_R2;
            state_in = ST_PLO;
         end
         ST_PLO: begin
            cmd.mul  = MUL_R2_LO;
            state_in = ST_PHI;
         end
         ST_PHI: begin
            cmd.mul  = MUL_R2_HI;
            cmd.act  = ACT_LO;
            state_in = ST_COMB;
         end
         ST_COMB: begin
            cmd.act  = ACT_COMB;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.act  = ACT_CMP;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.act      = ACT_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/mkg_datapath.sv -----
// Magnetometer Kalman gate: registers, shared multiplier, gain divider and filter state.
// Depends on mkg_pkg; driven one command per cycle by mkg_ctrl.
`default_nettype none

module mkg_datapath
   import mkg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   input  mkg_cmd_type               cmd,
   output logic                      spike,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic [VERDICT_WIDTH-1:0]  rsp_tuser
);

   function automatic logic [SAMPLE_WIDTH:0] abs_val(input logic signed [SAMPLE_WIDTH-1:0] v);
      logic signed [SAMPLE_WIDTH:0] w;
      w = (SAMPLE_WIDTH + 1)'(v);
      return w[SAMPLE_WIDTH] ? (SAMPLE_WIDTH + 1)'(-w) : (SAMPLE_WIDTH + 1)'(w);
   endfunction

   function automatic logic signed [EST_WIDTH-1:0] sat_est(input logic signed [EST_WIDTH+2:0] v);
      logic signed [EST_WIDTH+2:0] hi;
      logic signed [EST_WIDTH+2:0] lo;
      hi = (EST_WIDTH + 3)'((64'sd1 <<< (EST_WIDTH - 1)) - 64'sd1);
      lo = -hi - (EST_WIDTH + 3)'(1);
      if (v > hi) begin
         return EST_WIDTH'(hi);
      end else if (v < lo) begin
         return EST_WIDTH'(lo);
      end
      return EST_WIDTH'(v);
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] round_est(
      input logic signed [EST_WIDTH-1:0] e);
      logic signed [EST_WIDTH:0] t;
      logic signed [EST_WIDTH:0] hi;
      hi = (EST_WIDTH + 1)'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
      t  = ((EST_WIDTH + 1)'(e) + ((EST_WIDTH + 1)'(1) <<< (EXTRA_BITS - 1))) >>> EXTRA_BITS;
      if (t > hi) begin
         return SAMPLE_WIDTH'(hi);
      end
      return SAMPLE_WIDTH'(t);
   endfunction

   logic [SPIKE_LIMIT_WIDTH-1:0] spike_limit_ff;
   logic [PROC_NOISE_WIDTH-1:0]  proc_noise_ff;
   logic [MEAS_NOISE_WIDTH-1:0]  meas_noise_ff;
   logic [RATIO_WIDTH-1:0]       ratio_limit_ff;

   logic signed [EST_WIDTH-1:0]    est_ff [3];
   logic signed [EST_WIDTH-1:0]    est_in [3];
   logic [COV_WIDTH-1:0]           cov_ff, cov_in;
   logic                           spike_ff, spike_in;

   logic signed [SAMPLE_WIDTH-1:0] sample_ff [3];
   logic signed [SAMPLE_WIDTH-1:0] sample_in [3];
   logic signed [SAMPLE_WIDTH-1:0] f_ff [3];
   logic signed [SAMPLE_WIDTH-1:0] f_in [3];
   logic [ACC_WIDTH-1:0]           acc_ff, acc_in;
   logic [PROD_WIDTH-1:0]          prod_ff, prod_in;
   logic                           prod_neg_ff, prod_neg_in;
   logic [COV_WIDTH-1:0]           p_ff, p_in;
   logic [DEN_WIDTH-1:0]           den_ff, den_in;
   logic [REM_WIDTH-1:0]           rem_ff, rem_in;
   logic [GAIN_WIDTH-1:0]          quo_ff, quo_in;
   logic signed [DIFF_WIDTH-1:0]   d_ff, d_in;
   logic [ACC_WIDTH-1:0]           fz2_ff, fz2_in;
   logic [MUL_A_WIDTH-1:0]         r2_ff, r2_in;
   logic [LO_WIDTH-1:0]            lo_ff, lo_in;
   logic [RHS_WIDTH-1:0]           rhs_ff, rhs_in;
   verdict_type                    verdict_ff, verdict_in;
   logic [RSP_DATA_WIDTH-1:0]      rsp_tdata_ff, rsp_tdata_in;
   logic [VERDICT_WIDTH-1:0]       rsp_tuser_ff, rsp_tuser_in;

   logic [MUL_A_WIDTH-1:0]         mul_a;
   logic [MUL_B_WIDTH-1:0]         mul_b;
   logic [DIFF_WIDTH-1:0]          d_mag;
   logic [COV_WIDTH:0]             p_sum;
   logic [REM_WIDTH-1:0]           div_t;
   logic [REM_WIDTH-1:0]           div_r;
   logic                           div_ge;
   logic signed [LO_WIDTH-7:0]     gd;
   logic signed [LO_WIDTH-7:0]     gr;
   logic signed [EST_WIDTH+2:0]    en;

   assign spike     = spike_ff;
   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;

   assign d_mag = d_ff[DIFF_WIDTH-1] ? DIFF_WIDTH'(-d_ff) : DIFF_WIDTH'(d_ff);

   // shared multiplier operands
   always_comb begin
      mul_a       = '0;
      mul_b       = '0;
      prod_neg_in = prod_neg_ff;
      unique case (cmd.mul)
         MUL_NONE: begin
            mul_a = '0;
         end
         MUL_SQ_SAMPLE: begin
            mul_a = MUL_A_WIDTH'(abs_val(sample_ff[cmd.axis]));
            mul_b = MUL_B_WIDTH'(abs_val(sample_ff[cmd.axis]));
         end
         MUL_SQ_LIMIT: begin
            mul_a = MUL_A_WIDTH'(spike_limit_ff);
            mul_b = MUL_B_WIDTH'(spike_limit_ff);
         end
         MUL_GAIN_DIFF: begin
            mul_a       = MUL_A_WIDTH'(d_mag);
            mul_b       = MUL_B_WIDTH'(quo_ff);
            prod_neg_in = d_ff[DIFF_WIDTH-1];
         end
         MUL_COV: begin
            mul_a = MUL_A_WIDTH'(p_ff);
            mul_b = MUL_B_WIDTH'(GAIN_ONE - quo_ff);
         end
         MUL_SQ_EST: begin
            mul_a = MUL_A_WIDTH'(abs_val(f_ff[cmd.axis]));
            mul_b = MUL_B_WIDTH'(abs_val(f_ff[cmd.axis]));
         end
         MUL_SQ_RATIO: begin
            mul_a = MUL_A_WIDTH'(ratio_limit_ff);
            mul_b = MUL_B_WIDTH'(ratio_limit_ff);
         end
         MUL_R2_LO: begin
            mul_a = r2_ff;
            mul_b = MUL_B_WIDTH'(acc_ff[HALF_WIDTH-1:0]);
         end
         MUL_R2_HI: begin
            mul_a = r2_ff;
            mul_b = MUL_B_WIDTH'(acc_ff[ACC_WIDTH-1:HALF_WIDTH]);
         end
         default: begin
            mul_a = '0;
         end
      endcase
      prod_in = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);
   end

   always_comb begin
      p_sum  = (COV_WIDTH + 1)'(cov_ff) + (COV_WIDTH + 1)'(proc_noise_ff);
      div_t  = rem_ff;
      div_ge = (den_ff != '0) && (div_t >= REM_WIDTH'(den_ff));
      div_r  = div_ge ? div_t - REM_WIDTH'(den_ff) : div_t;
      gd     = prod_neg_ff ? -$signed({1'b0, prod_ff[LO_WIDTH-9:0]})
                           : $signed({1'b0, prod_ff[LO_WIDTH-9:0]});
      gr     = (gd + ((LO_WIDTH - 6)'(1) <<< (GAIN_FRAC_BITS - 1))) >>> GAIN_FRAC_BITS;
      en     = (EST_WIDTH + 3)'(est_ff[cmd.axis]) + (EST_WIDTH + 3)'(gr);

      est_in       = est_ff;
      cov_in       = cov_ff;
      spike_in     = spike_ff;
      sample_in    = sample_ff;
      f_in         = f_ff;
      acc_in       = acc_ff;
      p_in         = p_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      d_in         = d_ff;
      fz2_in       = fz2_ff;
      r2_in        = r2_ff;
      lo_in        = lo_ff;
      rhs_in       = rhs_ff;
      verdict_in   = verdict_ff;
      rsp_tdata_in = rsp_tdata_ff;
      rsp_tuser_in = rsp_tuser_ff;

      unique case (cmd.act)
         ACT_NONE: begin
            acc_in = acc_ff;
         end
         ACT_LOAD: begin
            sample_in[0] = req_tdata[SAMPLE_WIDTH-1:0];
            sample_in[1] = req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
            sample_in[2] = req_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];
            acc_in       = '0;
         end
         ACT_ACC: begin
            acc_in = acc_ff + prod_ff[ACC_WIDTH-1:0];
         end
         ACT_SPIKE: begin
            spike_in = acc_ff > prod_ff[ACC_WIDTH-1:0];
            p_in     = p_sum[COV_WIDTH] ? '1 : p_sum[COV_WIDTH-1:0];
         end
         ACT_DEN: begin
            den_in = DEN_WIDTH'(p_ff) + DEN_WIDTH'(meas_noise_ff);
            rem_in = REM_WIDTH'(p_ff);
            quo_in = '0;
         end
         ACT_DIV: begin
            quo_in = {quo_ff[GAIN_WIDTH-2:0], div_ge};
            rem_in = {div_r[REM_WIDTH-2:0], 1'b0};
         end
         ACT_DIFF: begin
            d_in = DIFF_WIDTH'($signed({sample_ff[cmd.axis], {EXTRA_BITS{1'b0}}}))
                 - DIFF_WIDTH'(est_ff[cmd.axis]);
         end
         ACT_UPD: begin
            est_in[cmd.axis] = sat_est(en);
         end
         ACT_COV: begin
            cov_in = prod_ff[COV_WIDTH+GAIN_FRAC_BITS-1:GAIN_FRAC_BITS];
         end
         ACT_ROUND: begin
            for (int i = 0; i < 3; i++) begin
               f_in[i] = round_est(est_ff[i]);
            end
            acc_in = '0;
         end
         ACT_ACC_Z: begin
            acc_in = acc_ff + prod_ff[ACC_WIDTH-1:0];
            fz2_in = prod_ff[ACC_WIDTH-1:0];
         end
         ACT_R2: begin
            r2_in = prod_ff[MUL_A_WIDTH-1:0];
         end
         ACT_LO: begin
            lo_in = prod_ff[LO_WIDTH-1:0];
         end
         ACT_COMB: begin
            rhs_in = {prod_ff[LO_WIDTH-1:0], {HALF_WIDTH{1'b0}}} + RHS_WIDTH'(lo_ff);
         end
         ACT_CMP: begin
            if ((acc_ff == '0) ||
                (RHS_WIDTH'({fz2_ff, {ACC_WIDTH{1'b0}}}) < rhs_ff)) begin
               verdict_in = VERDICT_RATIO;
            end else begin
               verdict_in = VERDICT_ACCEPT;
            end
         end
         ACT_OUT: begin
            rsp_tdata_in = {f_ff[2], f_ff[1], f_ff[0]};
            rsp_tuser_in = spike_ff ? VERDICT_SPIKE : verdict_ff;
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spike_limit_ff <= SPIKE_LIMIT_RESET;
         proc_noise_ff  <= PROC_NOISE_RESET;
         meas_noise_ff  <= MEAS_NOISE_RESET;
         ratio_limit_ff <= RATIO_RESET;
         est_ff[0]      <= '0;
         est_ff[1]      <= '0;
         est_ff[2]      <= '0;
         cov_ff         <= COV_RESET;
         spike_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_addr))
               CSR_SPIKE_LIMIT:   spike_limit_ff <= csr_wdata[SPIKE_LIMIT_WIDTH-1:0];
               CSR_PROCESS_NOISE: proc_noise_ff  <= csr_wdata[PROC_NOISE_WIDTH-1:0];
               CSR_MEAS_NOISE:    meas_noise_ff  <= csr_wdata[MEAS_NOISE_WIDTH-1:0];
               CSR_RATIO_LIMIT:   ratio_limit_ff <= csr_wdata[RATIO_WIDTH-1:0];
               default:           spike_limit_ff <= spike_limit_ff;
            endcase
         end
         est_ff   <= est_in;
         cov_ff   <= cov_in;
         spike_ff <= spike_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      f_ff         <= f_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      prod_neg_ff  <= prod_neg_in;
      p_ff         <= p_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      d_ff         <= d_in;
      fz2_ff       <= fz2_in;
      r2_ff        <= r2_in;
      lo_ff        <= lo_in;
      rhs_ff       <= rhs_in;
      verdict_ff   <= verdict_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

endmodule

`default_nettype wire
